// ===== src/window_pixel_address_writer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// window pixel address writer - assertion macros
// shared assertion shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef WINDOW_PIXEL_ADDRESS_WRITER_UNIT_MACROS_SVH
`define WINDOW_PIXEL_ADDRESS_WRITER_UNIT_MACROS_SVH

// property checked only outside reset
`define WPAW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked at every edge, reset included
`define WPAW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/wpaw_pkg.sv =====
// ----------------------------------------------------------------------------
// wpaw_pkg
// types and constants of the window pixel address writer
// ----------------------------------------------------------------------------
`default_nettype none

package wpaw_pkg;

    localparam int DEFAULT_COORD_BITS = 12;

    localparam int CFG_DATA_W = 15;
    localparam int CFG_ADDR_W = 3;
    localparam int ADDR_W     = 26;

    // register indexes of the configuration port
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROTATION     = 3'd0,
        REG_WIDTH        = 3'd1,
        REG_HEIGHT       = 3'd2,
        REG_LINE_BYTES   = 3'd3,
        REG_PIXEL_FORMAT = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FMT_RGB565   = 2'd0,
        FMT_RGB888   = 2'd1,
        FMT_ARGB8888 = 2'd2
    } pixel_format_t;

    typedef enum logic {
        ACT_SET_WINDOW = 1'b0,
        ACT_PIXEL      = 1'b1
    } action_t;

    // rotation codes that mirror the y axis
    localparam logic [7:0] MIRROR_Y_SET = 8'b1001_0110;

    localparam logic [2:0]  ROTATION_RESET   = 3'd0;
    localparam logic [12:0] WIDTH_RESET      = 13'd320;
    localparam logic [12:0] HEIGHT_RESET     = 13'd240;
    localparam logic [14:0] LINE_BYTES_RESET = 15'd640;

    localparam logic [2:0] BYTES_RGB565   = 3'd2;
    localparam logic [2:0] BYTES_RGB888   = 3'd3;
    localparam logic [2:0] BYTES_ARGB8888 = 3'd4;

endpackage

`default_nettype wire

// ===== src/window_pixel_address_writer_unit.sv =====
// ----------------------------------------------------------------------------
// window_pixel_address_writer_unit
// frame buffer write engine: address window, cursor, rotation, color repack
// ----------------------------------------------------------------------------
// a pixel request passes through stage 1 and then the result register on its way to m_*
// throughput: one request per cycle, set-window and pixel alike, while no stalled result holds s_ready low
// set-window requests and pixels in a format with no code give no result
// reset (aresetn low at a clock edge) empties both stages, zeroes cursor and
// window, and loads the configuration defaults (320 x 240, rgb565)
`default_nettype none

module window_pixel_address_writer_unit #(
    parameter int COORD_BITS = wpaw_pkg::DEFAULT_COORD_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    // configuration writes: the user must write only while idle; not enforced here
    input  wire logic                            cfg_wr_en,
    input  wire logic [wpaw_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [wpaw_pkg::CFG_DATA_W-1:0] cfg_wdata,

    // request channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_action,
    input  wire logic [15:0]                     s_x_start,
    input  wire logic [15:0]                     s_y_start,
    input  wire logic [15:0]                     s_x_end,
    input  wire logic [15:0]                     s_y_end,
    input  wire logic [31:0]                     s_color,

    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [wpaw_pkg::ADDR_W-1:0]          m_byte_address,
    output logic [31:0]                          m_pixel_data,
    output logic [2:0]                           m_byte_count
);

    // width of the bound arithmetic: holds any 16-bit input plus one
    localparam int BW        = 17;
    localparam logic [BW-1:0] COORD_MAX = BW'((64'd1 << COORD_BITS) - 64'd1);
    localparam int PROD_W    = COORD_BITS + 16;
    localparam int SUM_W     = (PROD_W > wpaw_pkg::ADDR_W) ? PROD_W : wpaw_pkg::ADDR_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [2:0]  rotation_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [14:0] line_bytes_reg;
    logic [1:0]  pixel_format_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg     <= wpaw_pkg::ROTATION_RESET;
            width_reg        <= wpaw_pkg::WIDTH_RESET;
            height_reg       <= wpaw_pkg::HEIGHT_RESET;
            line_bytes_reg   <= wpaw_pkg::LINE_BYTES_RESET;
            pixel_format_reg <= wpaw_pkg::FMT_RGB565;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                wpaw_pkg::REG_ROTATION:     rotation_reg     <= cfg_wdata[2:0];
                wpaw_pkg::REG_WIDTH:        width_reg        <= cfg_wdata[12:0];
                wpaw_pkg::REG_HEIGHT:       height_reg       <= cfg_wdata[12:0];
                wpaw_pkg::REG_LINE_BYTES:   line_bytes_reg   <= cfg_wdata[14:0];
                wpaw_pkg::REG_PIXEL_FORMAT: pixel_format_reg <= cfg_wdata[1:0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: two registered stages, each refills as it drains
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg,  m_valid_next;
    logic out_ready;
    logic s_accept;

    assign out_ready = !m_valid_reg || m_ready;
    // stage 1 always moves on when the result register can take it
    assign s_ready   = !s1_valid_reg || out_ready;
    assign s_accept  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // window and cursor, updated at the accept edge
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] cursor_x_reg,      cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_reg,      cursor_y_next;
    logic [COORD_BITS-1:0] window_left_reg,   window_left_next;
    logic [COORD_BITS-1:0] window_right_reg,  window_right_next;
    logic [COORD_BITS-1:0] window_top_reg,    window_top_next;
    logic [COORD_BITS-1:0] window_bottom_reg, window_bottom_next;

    // largest legal coordinate for a panel size, saturated to the coordinate range
    function automatic logic [BW-1:0] bound_of(input logic [12:0] size);
        logic [BW-1:0] b;
        b = (size == 13'd0) ? '0 : (BW'(size) - BW'(1));
        return (b > COORD_MAX) ? COORD_MAX : b;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_to(input logic [15:0]   v,
                                                       input logic [BW-1:0] b);
        logic [BW-1:0] r;
        r = (BW'(v) > b) ? b : BW'(v);
        return r[COORD_BITS-1:0];
    endfunction

    logic [BW-1:0]       bound_x, bound_y;
    logic [COORD_BITS:0] x_inc, y_inc;
    logic                pixel_req;
    logic                format_known;

    assign bound_x = bound_of(width_reg);
    assign bound_y = bound_of(height_reg);
    assign x_inc   = {1'b0, cursor_x_reg} + 1'b1;
    assign y_inc   = {1'b0, cursor_y_reg} + 1'b1;
    assign pixel_req    = (s_action == wpaw_pkg::ACT_PIXEL);
    assign format_known = (pixel_format_reg == wpaw_pkg::FMT_RGB565)   ||
                          (pixel_format_reg == wpaw_pkg::FMT_RGB888)   ||
                          (pixel_format_reg == wpaw_pkg::FMT_ARGB8888);

    always_comb begin
        window_left_next   = window_left_reg;
        window_right_next  = window_right_reg;
        window_top_next    = window_top_reg;
        window_bottom_next = window_bottom_reg;
        cursor_x_next      = cursor_x_reg;
        cursor_y_next      = cursor_y_reg;
        if (s_accept) begin
            if (!pixel_req) begin
                // new window, cursor to its top-left corner
                window_left_next   = clamp_to(s_x_start, bound_x);
                window_top_next    = clamp_to(s_y_start, bound_y);
                window_right_next  = clamp_to(s_x_end,   bound_x);
                window_bottom_next = clamp_to(s_y_end,   bound_y);
                cursor_x_next      = window_left_next;
                cursor_y_next      = window_top_next;
            end else if (x_inc <= {1'b0, window_right_reg}) begin
                cursor_x_next = x_inc[COORD_BITS-1:0];
            end else begin
                // end of row: back to left edge, next row or wrap to top
                cursor_x_next = window_left_reg;
                if (y_inc > {1'b0, window_bottom_reg}) begin
                    cursor_y_next = window_top_reg;
                end else begin
                    cursor_y_next = y_inc[COORD_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg      <= '0;
            cursor_y_reg      <= '0;
            window_left_reg   <= '0;
            window_right_reg  <= '0;
            window_top_reg    <= '0;
            window_bottom_reg <= '0;
        end else begin
            cursor_x_reg      <= cursor_x_next;
            cursor_y_reg      <= cursor_y_next;
            window_left_reg   <= window_left_next;
            window_right_reg  <= window_right_next;
            window_top_reg    <= window_top_next;
            window_bottom_reg <= window_bottom_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: pixel requests that give a result, with the cursor they hit
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] s1_x_reg;
    logic [COORD_BITS-1:0] s1_y_reg;
    logic [31:0]           s1_color_reg;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_ready) begin
            s1_valid_next = s_accept && pixel_req && format_known;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_x_reg     <= cursor_x_reg;
            s1_y_reg     <= cursor_y_reg;
            s1_color_reg <= s_color;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: rotation, address and color repack into the result register
    // ------------------------------------------------------------------
    logic [BW-1:0]         mirror_x_full, mirror_y_full;
    logic [COORD_BITS-1:0] rx, ry, phys_x, phys_y;
    logic [SUM_W-1:0]      x_term, y_term, addr_sum;
    logic [31:0]           data_c;
    logic [2:0]            bytes_c;

    // mirrored coordinate taken modulo the coordinate range
    assign mirror_y_full = BW'(height_reg) - BW'(s1_y_reg) - BW'(1);
    assign mirror_x_full = BW'(width_reg)  - BW'(s1_x_reg) - BW'(1);

    assign ry = wpaw_pkg::MIRROR_Y_SET[rotation_reg] ? mirror_y_full[COORD_BITS-1:0]
                                                     : s1_y_reg;
    assign rx = rotation_reg[1] ? mirror_x_full[COORD_BITS-1:0] : s1_x_reg;

    // swap axes last
    assign phys_x = rotation_reg[0] ? ry : rx;
    assign phys_y = rotation_reg[0] ? rx : ry;

    always_comb begin
        unique case (pixel_format_reg)
            wpaw_pkg::FMT_RGB565: begin
                // source GGGBBBBB RRRRRGGG -> r:g:b
                data_c  = {16'd0, s1_color_reg[7:3], s1_color_reg[15:13],
                           s1_color_reg[2:0], s1_color_reg[12:8]};
                bytes_c = wpaw_pkg::BYTES_RGB565;
                x_term  = SUM_W'(phys_x) << 1;
            end
            wpaw_pkg::FMT_RGB888: begin
                data_c  = {8'd0, s1_color_reg[7:0], s1_color_reg[15:8],
                           s1_color_reg[23:16]};
                bytes_c = wpaw_pkg::BYTES_RGB888;
                x_term  = (SUM_W'(phys_x) << 1) + SUM_W'(phys_x);
            end
            wpaw_pkg::FMT_ARGB8888: begin
                data_c  = {s1_color_reg[7:0], s1_color_reg[15:8],
                           s1_color_reg[23:16], s1_color_reg[31:24]};
                bytes_c = wpaw_pkg::BYTES_ARGB8888;
                x_term  = SUM_W'(phys_x) << 2;
            end
            default: begin
                // never loaded into stage 1
                data_c  = '0;
                bytes_c = wpaw_pkg::BYTES_RGB565;
                x_term  = '0;
            end
        endcase
    end

    assign y_term   = SUM_W'(phys_y) * SUM_W'(line_bytes_reg);
    assign addr_sum = y_term + x_term;

    logic [wpaw_pkg::ADDR_W-1:0] m_byte_address_reg;
    logic [31:0]                 m_pixel_data_reg;
    logic [2:0]                  m_byte_count_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_ready) begin
            m_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && s1_valid_reg) begin
            m_byte_address_reg <= addr_sum[wpaw_pkg::ADDR_W-1:0];
            m_pixel_data_reg   <= data_c;
            m_byte_count_reg   <= bytes_c;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_byte_address = m_byte_address_reg;
    assign m_pixel_data   = m_pixel_data_reg;
    assign m_byte_count   = m_byte_count_reg;

endmodule

`default_nettype wire

// ===== src/wpaw_checker.sv =====
// ----------------------------------------------------------------------------
// wpaw_checker
// port-level checks of the window pixel address writer
// ----------------------------------------------------------------------------
`default_nettype none

`include "window_pixel_address_writer_unit_macros.svh"

module wpaw_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [wpaw_pkg::ADDR_W-1:0] m_byte_address,
    input wire logic [31:0]                 m_pixel_data,
    input wire logic [2:0]                  m_byte_count
);

    // byte count is one of the three packings
    logic count_legal;
    // unused high bytes are zero
    logic high_bytes_zero;

    assign count_legal = (m_byte_count == wpaw_pkg::BYTES_RGB565) ||
                         (m_byte_count == wpaw_pkg::BYTES_RGB888) ||
                         (m_byte_count == wpaw_pkg::BYTES_ARGB8888);

    assign high_bytes_zero = (m_byte_count != wpaw_pkg::BYTES_RGB565 ||
                              m_pixel_data[31:16] == 16'd0) &&
                             (m_byte_count != wpaw_pkg::BYTES_RGB888 ||
                              m_pixel_data[31:24] == 8'd0);

    property p_stall_holds;
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_byte_address) && $stable(m_pixel_data));
    endproperty

    // results never show in the cycle after reset
    `WPAW_ASSERT_ALWAYS(a_no_result_after_reset, $past(!aresetn) |-> !m_valid, "early result")

    `WPAW_ASSERT(a_count_legal, m_valid |-> count_legal, "bad byte count")

    `WPAW_ASSERT(a_high_bytes_zero, m_valid |-> high_bytes_zero, "data beyond byte count")

    `WPAW_ASSERT(a_stall_holds, p_stall_holds, "stalled result changed")

endmodule

bind window_pixel_address_writer_unit wpaw_checker u_wpaw_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_byte_address (m_byte_address),
    .m_pixel_data   (m_pixel_data),
    .m_byte_count   (m_byte_count)
);

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// window pixel address writer - self-checking testbench
// drives set-window and pixel requests through a table of directed rows and
// then through random phases of window runs under several register settings;
// a behavioral predictor of cursor, rotation and color repack supplies the
// expected frame buffer writes, compared field by field in order of arrival
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int          COORD_BITS    = wpaw_pkg::DEFAULT_COORD_BITS;
    localparam int unsigned COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int          RESET_CYCLES  = 10;
    localparam int          SETTLE_CYCLES = 8;      // pipeline is two deep, plus margin
    localparam int          HOLD_CYCLES   = 400;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          PHASES        = 10;
    localparam int          FIXED_PHASES  = 6;
    localparam int          PHASE_ITEMS   = 80;
    localparam int          DIRECTED_ROWS = 25;
    localparam int          MAX_REPORTS   = 40;

    // pixel format code that has no packing and gives no write
    localparam logic [1:0] FMT_NONE = 2'd3;

    typedef logic [wpaw_pkg::CFG_ADDR_W-1:0] cfg_addr_t;
    typedef logic [wpaw_pkg::CFG_DATA_W-1:0] cfg_data_t;

    typedef struct packed {
        logic [wpaw_pkg::ADDR_W-1:0] byte_address;
        logic [31:0]                 pixel_data;
        logic [2:0]                  byte_count;
    } pixel_write_t;

    // one request; pinned rows carry a write typed in by hand
    typedef struct packed {
        wpaw_pkg::action_t action;
        logic [15:0]       x_start;
        logic [15:0]       y_start;
        logic [15:0]       x_end;
        logic [15:0]       y_end;
        logic [31:0]       color;
        logic              pinned;
        pixel_write_t      want;
    } request_t;

    typedef struct packed {
        cfg_data_t rotation;
        cfg_data_t width;
        cfg_data_t height;
        cfg_data_t line_bytes;
        cfg_data_t pixel_format;
    } settings_t;

    localparam pixel_write_t NO_WRITE  = '0;
    localparam logic [15:0]  COORD_ALL = 16'hFFFF;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    cfg_addr_t                   cfg_addr;
    cfg_data_t                   cfg_wdata;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_action;
    logic [15:0]                 s_x_start;
    logic [15:0]                 s_y_start;
    logic [15:0]                 s_x_end;
    logic [15:0]                 s_y_end;
    logic [31:0]                 s_color;
    logic                        m_valid;
    logic                        m_ready;
    logic [wpaw_pkg::ADDR_W-1:0] m_byte_address;
    logic [31:0]                 m_pixel_data;
    logic [2:0]                  m_byte_count;

    // side band that travels with the request payload
    logic                  pin_valid;
    pixel_write_t          pin_write;

    // predictor copy of the registers
    int unsigned cfg_rotation;
    int unsigned cfg_width;
    int unsigned cfg_height;
    int unsigned cfg_line_bytes;
    int unsigned cfg_format;

    // predictor copy of cursor and window
    int unsigned cur_x;
    int unsigned cur_y;
    int unsigned win_left;
    int unsigned win_right;
    int unsigned win_top;
    int unsigned win_bottom;

    pixel_write_t pending_writes [$];

    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_request;
    int          hold_left;
    int unsigned cycle_count;

    window_pixel_address_writer_unit #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_x_start      (s_x_start),
        .s_y_start      (s_y_start),
        .s_x_end        (s_x_end),
        .s_y_end        (s_y_end),
        .s_color        (s_color),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_address (m_byte_address),
        .m_pixel_data   (m_pixel_data),
        .m_byte_count   (m_byte_count)
    );

    // directed rows, run at the reset settings: 320 x 240, rgb565, no rotation,
    // window and cursor all zero
    request_t directed_rows [DIRECTED_ROWS] = '{
        // zero window after reset: every pixel lands on the origin
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0000,
          1'b1, '{26'd0, 32'h0000_0000, wpaw_pkg::BYTES_RGB565}},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF,
          1'b1, '{26'd0, 32'h0000_FFFF, wpaw_pkg::BYTES_RGB565}},
        // bounds far past the panel clamp to the bottom right pixel
        '{wpaw_pkg::ACT_SET_WINDOW, COORD_ALL, COORD_ALL, COORD_ALL, COORD_ALL, 32'h0,
          1'b0, NO_WRITE},
        // one color component at a time: red, blue, green
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_00F8,
          1'b1, '{26'd153598, 32'h0000_F800, wpaw_pkg::BYTES_RGB565}},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_1F00,
          1'b1, '{26'd153598, 32'h0000_001F, wpaw_pkg::BYTES_RGB565}},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_E007,
          1'b1, '{26'd153598, 32'h0000_07E0, wpaw_pkg::BYTES_RGB565}},
        // 3 x 2 window, seven pixels so the cursor comes back to the start
        '{wpaw_pkg::ACT_SET_WINDOW, 16'd10, 16'd5, 16'd12, 16'd6, 32'h0, 1'b0, NO_WRITE},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'h1234_5678, 1'b0, NO_WRITE},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'h9ABC_DEF0, 1'b0, NO_WRITE},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0F0F_0F0F, 1'b0, NO_WRITE},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'hF0F0_F0F0, 1'b0, NO_WRITE},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'h00FF_00FF, 1'b0, NO_WRITE},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'hFF00_FF00, 1'b0, NO_WRITE},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'h8000_0001, 1'b0, NO_WRITE},
        // inverted window: every step wraps to the left edge and top row
        '{wpaw_pkg::ACT_SET_WINDOW, 16'd20, 16'd30, 16'd10, 16'd5, 32'h0, 1'b0, NO_WRITE},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'hDEAD_BEEF, 1'b0, NO_WRITE},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'hCAFE_F00D, 1'b0, NO_WRITE},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0001, 1'b0, NO_WRITE},
        // full-width single row, right bound clamped
        '{wpaw_pkg::ACT_SET_WINDOW, 16'd0, 16'd0, COORD_ALL, 16'd0, 32'h0, 1'b0, NO_WRITE},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'hAAAA_5555, 1'b0, NO_WRITE},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'h5555_AAAA, 1'b0, NO_WRITE},
        // bottom right corner, wrap on the last row back to the top
        '{wpaw_pkg::ACT_SET_WINDOW, 16'd318, 16'd239, 16'd319, 16'd239, 32'h0,
          1'b0, NO_WRITE},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'h7FFF_FFFF, 1'b0, NO_WRITE},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFE, 1'b0, NO_WRITE},
        '{wpaw_pkg::ACT_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_8000, 1'b0, NO_WRITE}
    };

    // register settings for the first phases; later phases pick at random
    settings_t fixed_settings [FIXED_PHASES] = '{
        '{15'd1,     15'd64,    15'd48,   15'd128,   15'(wpaw_pkg::FMT_RGB888)},
        // zero size, all-ones rotation word
        '{15'h7FFF,  15'd0,     15'd0,    15'd0,     15'(wpaw_pkg::FMT_ARGB8888)},
        // size past the coordinate range, widest stride: address wraps
        '{15'd5,     15'h7FFF,  15'd4096, 15'h7FFF,  15'(wpaw_pkg::FMT_ARGB8888)},
        // format with no packing: cursor moves, nothing comes out
        '{15'd2,     15'd16,    15'd12,   15'd100,   15'(FMT_NONE)},
        '{15'd4,     15'd4096,  15'd1,    15'd1,     15'(wpaw_pkg::FMT_RGB565)},
        '{15'd6,     15'd1,     15'd4096, 15'd16384, 15'(wpaw_pkg::FMT_RGB888)}
    };

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic int unsigned size_bound(input int unsigned size);
        int unsigned b;
        b = (size == 0) ? 0 : size - 1;
        return (b > COORD_MAX) ? COORD_MAX : b;
    endfunction

    function automatic int unsigned clamp_coord(input int unsigned v,
                                                input int unsigned b);
        return (v > b) ? b : v;
    endfunction

    // applies one request to the predictor state; returns 1 when a write
    // to the frame buffer is due, with that write in wr
    function automatic logic predict_request(input wpaw_pkg::action_t act,
                                             input logic [15:0] xs,
                                             input logic [15:0] ys,
                                             input logic [15:0] xe,
                                             input logic [15:0] ye,
                                             input logic [31:0] raw,
                                             output pixel_write_t wr);
        int unsigned px;
        int unsigned py;
        int unsigned swap_v;
        int unsigned bytes;
        logic [31:0] data;
        logic [63:0] addr;
        logic        emits;
        wr = NO_WRITE;
        if (act == wpaw_pkg::ACT_SET_WINDOW) begin
            win_left   = clamp_coord(32'(xs), size_bound(cfg_width));
            win_top    = clamp_coord(32'(ys), size_bound(cfg_height));
            win_right  = clamp_coord(32'(xe), size_bound(cfg_width));
            win_bottom = clamp_coord(32'(ye), size_bound(cfg_height));
            cur_x = win_left;
            cur_y = win_top;
            return 1'b0;
        end

        // rotation: mirror y, mirror x, then swap
        px = cur_x;
        py = cur_y;
        if (wpaw_pkg::MIRROR_Y_SET[cfg_rotation[2:0]])
            py = (cfg_height - (py + 1)) & COORD_MAX;
        if (cfg_rotation[1])
            px = (cfg_width - (px + 1)) & COORD_MAX;
        if (cfg_rotation[0]) begin
            swap_v = px;
            px = py;
            py = swap_v;
        end

        emits = 1'b1;
        data  = '0;
        bytes = 0;
        case (cfg_format)
            wpaw_pkg::FMT_RGB565: begin
                // GGGBBBBB RRRRRGGG -> RRRRRGGG GGGBBBBB
                data  = {16'h0, raw[7:3], raw[15:13], raw[2:0], raw[12:8]};
                bytes = 32'(wpaw_pkg::BYTES_RGB565);
            end
            wpaw_pkg::FMT_RGB888: begin
                data  = {8'h0, raw[7:0], raw[15:8], raw[23:16]};
                bytes = 32'(wpaw_pkg::BYTES_RGB888);
            end
            wpaw_pkg::FMT_ARGB8888: begin
                data  = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
                bytes = 32'(wpaw_pkg::BYTES_ARGB8888);
            end
            default: begin
                emits = 1'b0;
            end
        endcase

        if (emits) begin
            addr = 64'(px) * 64'(bytes) + 64'(py) * 64'(cfg_line_bytes);
            wr.byte_address = addr[wpaw_pkg::ADDR_W-1:0];
            wr.pixel_data   = data;
            wr.byte_count   = bytes[2:0];
        end

        // step right, wrap to the left edge and down, back to the top row
        if (cur_x + 1 <= win_right) begin
            cur_x = (cur_x + 1) & COORD_MAX;
        end else begin
            cur_x = win_left;
            if (cur_y + 1 > win_bottom)
                cur_y = win_top;
            else
                cur_y = (cur_y + 1) & COORD_MAX;
        end
        return emits;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("%0t mismatch: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------------

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial cycle_count = 0;
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // observer: tracks config writes and accepted requests, checks writes
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin : observe
        pixel_write_t predicted;
        pixel_write_t want;
        if (!aresetn) begin
            cfg_rotation   = 32'(wpaw_pkg::ROTATION_RESET);
            cfg_width      = 32'(wpaw_pkg::WIDTH_RESET);
            cfg_height     = 32'(wpaw_pkg::HEIGHT_RESET);
            cfg_line_bytes = 32'(wpaw_pkg::LINE_BYTES_RESET);
            cfg_format     = 32'(wpaw_pkg::FMT_RGB565);
            cur_x      = 0;
            cur_y      = 0;
            win_left   = 0;
            win_right  = 0;
            win_top    = 0;
            win_bottom = 0;
            pending_writes.delete();
        end else begin
            // a write leaves the pipeline
            if (m_valid && m_ready) begin
                if (pending_writes.size() == 0) begin
                    report_mismatch($sformatf("write to %h with nothing pending",
                                              m_byte_address));
                end else begin
                    want = pending_writes.pop_front();
                    if (m_byte_address !== want.byte_address)
                        report_mismatch($sformatf("byte_address %h, expected %h",
                                                  m_byte_address, want.byte_address));
                    if (m_pixel_data !== want.pixel_data)
                        report_mismatch($sformatf("pixel_data %h, expected %h",
                                                  m_pixel_data, want.pixel_data));
                    if (m_byte_count !== want.byte_count)
                        report_mismatch($sformatf("byte_count %0d, expected %0d",
                                                  m_byte_count, want.byte_count));
                end
            end

            // register write; unknown indexes leave everything alone
            if (cfg_wr_en) begin
                case (cfg_addr)
                    wpaw_pkg::REG_ROTATION:     cfg_rotation   = 32'(cfg_wdata[2:0]);
                    wpaw_pkg::REG_WIDTH:        cfg_width      = 32'(cfg_wdata[12:0]);
                    wpaw_pkg::REG_HEIGHT:       cfg_height     = 32'(cfg_wdata[12:0]);
                    wpaw_pkg::REG_LINE_BYTES:   cfg_line_bytes = 32'(cfg_wdata[14:0]);
                    wpaw_pkg::REG_PIXEL_FORMAT: cfg_format     = 32'(cfg_wdata[1:0]);
                    default: ;
                endcase
            end

            // request accepted; a pinned row stands in for the predictor
            if (s_valid && s_ready) begin
                if (predict_request(wpaw_pkg::action_t'(s_action), s_x_start, s_y_start,
                                    s_x_end, s_y_end, s_color, predicted))
                    pending_writes.push_back(pin_valid ? pin_write : predicted);
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------

    initial begin
        m_ready   <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // offers one request, with a random gap first, and returns at the edge
    // where it is taken
    task automatic send_request(input request_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_action  <= req.action;
        s_x_start <= req.x_start;
        s_y_start <= req.y_start;
        s_x_end   <= req.x_end;
        s_y_end   <= req.y_end;
        s_color   <= req.color;
        pin_valid <= req.pinned;
        pin_write <= req.want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering, let every write come out, then let the pipe settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        // let the observer book the last request first
        @(posedge aclk);
        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one register write per edge; the caller lowers the enable after a group
    task automatic write_register(input cfg_addr_t idx,
                                  input cfg_data_t val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // pixel request; the window fields carry noise the block ignores
    function automatic request_t random_pixel();
        request_t req;
        req.action  = wpaw_pkg::ACT_PIXEL;
        req.x_start = 16'($urandom);
        req.y_start = 16'($urandom);
        req.x_end   = 16'($urandom);
        req.y_end   = 16'($urandom);
        req.color   = $urandom;
        req.pinned  = 1'b0;
        req.want    = NO_WRITE;
        return req;
    endfunction

    initial begin : stimulus
        request_t    req;
        settings_t   setting;
        int          budget;
        int          run;
        int          pick;
        int          phase;
        int          k;
        int unsigned spare_idx;

        error_count   = 0;
        hold_request  = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 75;

        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_action  <= wpaw_pkg::ACT_SET_WINDOW;
        s_x_start <= '0;
        s_y_start <= '0;
        s_x_end   <= '0;
        s_y_end   <= '0;
        s_color   <= '0;
        pin_valid <= 1'b0;
        pin_write <= NO_WRITE;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table at the reset settings
        for (k = 0; k < DIRECTED_ROWS; k++)
            send_request(directed_rows[k]);
        wait_drained();

        for (phase = 0; phase < PHASES; phase++) begin
            // idling: sender light and receiver heavy, then swapped, then none
            if (phase == 4) begin
                send_idle_pct = 75;
                recv_idle_pct = 21;
            end
            if (phase == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (phase < FIXED_PHASES) begin
                setting = fixed_settings[phase];
            end else begin
                setting.rotation     = 15'($urandom_range(0, 7));
                setting.width        = 15'($urandom_range(1, 320));
                setting.height       = 15'($urandom_range(1, 240));
                setting.line_bytes   = 15'($urandom_range(0, 15'h7FFF));
                setting.pixel_format = 15'($urandom_range(32'(wpaw_pkg::FMT_RGB565),
                                                          32'(wpaw_pkg::FMT_ARGB8888)));
            end

            // block is idle here; a write to an unused index comes along too
            spare_idx = $urandom_range(32'(wpaw_pkg::REG_PIXEL_FORMAT) + 1,
                                       (1 << wpaw_pkg::CFG_ADDR_W) - 1);
            write_register(cfg_addr_t'(spare_idx), cfg_data_t'($urandom_range(0, 15'h7FFF)));
            write_register(wpaw_pkg::REG_ROTATION, setting.rotation);
            write_register(wpaw_pkg::REG_WIDTH, setting.width);
            write_register(wpaw_pkg::REG_HEIGHT, setting.height);
            write_register(wpaw_pkg::REG_LINE_BYTES, setting.line_bytes);
            write_register(wpaw_pkg::REG_PIXEL_FORMAT, setting.pixel_format);
            cfg_wr_en <= 1'b0;

            // long receiver hold-off while requests keep coming, so the
            // pipeline fills and back-pressures the sender
            if (phase == 8)
                hold_request = 1'b1;

            // pixels first: cursor left from the old window, maybe off-panel
            budget = PHASE_ITEMS;
            run    = $urandom_range(1, 6);
            repeat (run) begin
                send_request(random_pixel());
                budget--;
            end

            while (budget > 0) begin
                pick = $urandom_range(99);
                req.action = wpaw_pkg::ACT_SET_WINDOW;
                req.color  = $urandom;
                req.pinned = 1'b0;
                req.want   = NO_WRITE;
                if (pick < 10) begin
                    // noise: bounds anywhere in the field range
                    req.x_start = 16'($urandom_range(0, 16'hFFFF));
                    req.y_start = 16'($urandom_range(0, 16'hFFFF));
                    req.x_end   = 16'($urandom_range(0, 16'hFFFF));
                    req.y_end   = 16'($urandom_range(0, 16'hFFFF));
                    run = $urandom_range(0, 3);
                end else begin
                    // small window near or on the panel, inverted now and then
                    req.x_start = 16'($urandom_range(0, cfg_width));
                    req.y_start = 16'($urandom_range(0, cfg_height));
                    if (pick < 20) begin
                        req.x_end = 16'($urandom_range(0, 32'(req.x_start)));
                        req.y_end = 16'($urandom_range(0, 32'(req.y_start)));
                    end else begin
                        req.x_end = req.x_start + 16'($urandom_range(0, 6));
                        req.y_end = req.y_start + 16'($urandom_range(0, 4));
                    end
                    run = $urandom_range(1, 24);
                end
                send_request(req);
                budget--;
                for (k = 0; k < run && budget > 0; k++) begin
                    send_request(random_pixel());
                    budget--;
                end
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
